// File: design/ic88_pkg.sv
// Shared types and constants for the 8+8 line interrupt controller.
`default_nettype none

package ic88_pkg;

    // Item kinds on the request channel
    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_RAISE = 2'd2,
        OP_ACK   = 2'd3
    } op_t;

    // Command port decode
    localparam logic [7:0] EOI_NONSPECIFIC = 8'h20;
    localparam logic [7:0] OCW_KIND_MASK   = 8'h18;
    localparam logic [7:0] OCW3_KIND       = 8'h08;
    localparam int         ICW1_BIT        = 4;
    localparam int         OCW3_RR_BIT     = 1;
    localparam int         OCW3_RIS_BIT    = 0;

    // Port select codes
    localparam logic       PORT_COMMAND    = 1'b0;

    localparam int NUM_LINES = 16;
    localparam int LINE_W    = 4;

    // Priority encoder result
    typedef struct packed {
        logic              found;
        logic [LINE_W-1:0] number;
    } grant_t;

endpackage

`default_nettype wire

// File: design/ic88_prio_enc.sv
// Fixed-priority encoder: lowest-numbered pending line wins.
`default_nettype none

module ic88_prio_enc
    import ic88_pkg::*;
(
    input  wire logic [NUM_LINES-1:0] pending,
    output grant_t                    grant
);

    // Scan from the lowest-priority end so the lowest index is kept last
    always_comb
    begin
        grant = '0;
        for (int i = NUM_LINES - 1; i >= 0; i--)
        begin
            if (pending[i])
            begin
                grant.found  = 1'b1;
                grant.number = LINE_W'(i);
            end
        end
    end

endmodule

`default_nettype wire

// File: design/interrupt_controller_8_plus_8.sv
// Top level of the 8+8 line interrupt controller: item pipeline and state.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+------------------------------------
//  req     | in        | req_valid / req_stall | op, port_sel, write_data, irq_line
//  rsp     | out       | rsp_valid / rsp_stall | read_data, irq_found, irq_number
//
// One item per cycle while neither channel stalls: an item waits in the input register,
// then the state update and its result are written together into the state registers
// and the result register, where the result is presented until it is taken.
// The input register and the result register lie between acceptance and the response.
// Reset clears all request, in-service and mask bytes and selects the request byte
// for reads. A stall on rsp holds the result; req stalls only when the input
// register is full and cannot move forward.
`default_nettype none

module interrupt_controller_8_plus_8
    import ic88_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,

    input  wire logic              req_valid,
    output logic                   req_stall,
    input  wire logic [1:0]        op,
    input  wire logic              port_sel,
    input  wire logic [7:0]        write_data,
    input  wire logic [LINE_W-1:0] irq_line,

    output logic                   rsp_valid,
    input  wire logic              rsp_stall,
    output logic [7:0]             read_data,
    output logic                   irq_found,
    output logic [LINE_W-1:0]      irq_number
);

    // Pipeline control
    logic              s1_valid_reg;
    logic              rsp_valid_reg;
    logic              accept;
    logic              advance;

    // Input register
    op_t               s1_op_reg;
    logic              s1_port_reg;
    logic [7:0]        s1_data_reg;
    logic [LINE_W-1:0] s1_line_reg;

    // Controller state
    logic [7:0] m_req_reg,  m_req_next;
    logic [7:0] m_isr_reg,  m_isr_next;
    logic [7:0] m_mask_reg, m_mask_next;
    logic [7:0] s_req_reg,  s_req_next;
    logic [7:0] s_isr_reg,  s_isr_next;
    logic       rr_sel_reg, rr_sel_next;

    // Result register
    logic [7:0]        read_data_reg,  read_data_next;
    logic              irq_found_reg,  irq_found_next;
    logic [LINE_W-1:0] irq_number_reg, irq_number_next;

    logic [NUM_LINES-1:0] pending;
    grant_t               grant;

    // Handshake
    assign advance   = s1_valid_reg && (!rsp_valid_reg || !rsp_stall);
    assign req_stall = s1_valid_reg && !advance;
    assign accept    = req_valid && !req_stall;

    // Pending lines: masked master below, unmasked slave above
    assign pending = {s_req_reg, m_req_reg & ~m_mask_reg};

    ic88_prio_enc u_prio_enc
    (
        .pending (pending),
        .grant   (grant)
    );

    // Item execution
    always_comb
    begin
        m_req_next      = m_req_reg;
        m_isr_next      = m_isr_reg;
        m_mask_next     = m_mask_reg;
        s_req_next      = s_req_reg;
        s_isr_next      = s_isr_reg;
        rr_sel_next     = rr_sel_reg;
        read_data_next  = '0;
        irq_found_next  = 1'b0;
        irq_number_next = '0;

        unique case (s1_op_reg)
            OP_WRITE:
            begin
                if (s1_port_reg != PORT_COMMAND)
                begin
                    m_mask_next = s1_data_reg;
                end
                else
                begin
                    priority if (s1_data_reg == EOI_NONSPECIFIC)
                    begin
                        m_isr_next = '0;
                    end
                    else if ((s1_data_reg & OCW_KIND_MASK) == OCW3_KIND)
                    begin
                        if (s1_data_reg[OCW3_RR_BIT])
                        begin
                            rr_sel_next = s1_data_reg[OCW3_RIS_BIT];
                        end
                    end
                    else if (s1_data_reg[ICW1_BIT])
                    begin
                        m_mask_next = '0;
                        m_isr_next  = '0;
                        m_req_next  = '0;
                        rr_sel_next = 1'b1;
                    end
                    else
                    begin
                        // other OCW2 commands are ignored
                    end
                end
            end
            OP_READ:
            begin
                read_data_next = rr_sel_reg ? m_req_reg : m_isr_reg;
            end
            OP_RAISE:
            begin
                if (s1_line_reg[LINE_W-1])
                begin
                    s_req_next = s_req_reg | (8'd1 << s1_line_reg[LINE_W-2:0]);
                end
                else
                begin
                    m_req_next = m_req_reg | (8'd1 << s1_line_reg[LINE_W-2:0]);
                end
            end
            OP_ACK:
            begin
                irq_found_next  = grant.found;
                irq_number_next = grant.number;
                if (grant.found)
                begin
                    if (grant.number[LINE_W-1])
                    begin
                        s_req_next = s_req_reg & ~(8'd1 << grant.number[LINE_W-2:0]);
                        s_isr_next = s_isr_reg | (8'd1 << grant.number[LINE_W-2:0]);
                    end
                    else
                    begin
                        m_req_next = m_req_reg & ~(8'd1 << grant.number[LINE_W-2:0]);
                        m_isr_next = m_isr_reg | (8'd1 << grant.number[LINE_W-2:0]);
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
            m_req_reg     <= '0;
            m_isr_reg     <= '0;
            m_mask_reg    <= '0;
            s_req_reg     <= '0;
            s_isr_reg     <= '0;
            rr_sel_reg    <= 1'b1;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                rsp_valid_reg <= 1'b1;
                m_req_reg     <= m_req_next;
                m_isr_reg     <= m_isr_next;
                m_mask_reg    <= m_mask_next;
                s_req_reg     <= s_req_next;
                s_isr_reg     <= s_isr_next;
                rr_sel_reg    <= rr_sel_next;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg   <= op_t'(op);
            s1_port_reg <= port_sel;
            s1_data_reg <= write_data;
            s1_line_reg <= irq_line;
        end
        if (advance)
        begin
            read_data_reg  <= read_data_next;
            irq_found_reg  <= irq_found_next;
            irq_number_reg <= irq_number_next;
        end
    end

    assign rsp_valid  = rsp_valid_reg;
    assign read_data  = read_data_reg;
    assign irq_found  = irq_found_reg;
    assign irq_number = irq_number_reg;

endmodule

`default_nettype wire
